[rtl/greedy_change_dispense_assert.svh]
// ----------------------------------------------------------------------------
// greedy_change_dispense assertion macros
// shared property forms for the port-level checks of the change dispenser
// ----------------------------------------------------------------------------
`ifndef GREEDY_CHANGE_DISPENSE_ASSERT_SVH
`define GREEDY_CHANGE_DISPENSE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define GCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define GCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/gcd_pkg.sv]
// ----------------------------------------------------------------------------
// gcd_pkg
// shared types, codes and denomination tables of the change dispenser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gcd_pkg;

	localparam int SLOTS           = 8;
	localparam int SLOT_W          = 3;
	localparam int DUE_W           = 16;
	localparam int LOAD_W          = 16;
	localparam int QUOT_W          = 14;
	localparam int DENOM_W         = 10;
	localparam int RECIP_W         = 17;
	localparam int SHIFT_W         = 5;
	localparam int COUNT_WIDTH_DEF = 16;

	typedef logic [SLOT_W-1:0] slot_t;

	localparam slot_t SLOT_LAST = slot_t'(SLOTS - 1);

	// input item action codes; the fourth code is ignored
	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_CHANGE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_QUOT,
		ST_SUB,
		ST_FINISH
	} state_t;

	// request to the quotient unit
	typedef struct packed {
		slot_t              slot;
		logic [DUE_W-1:0]   due;
	} quot_req_t;

	// slot 0 is the largest denomination
	localparam logic [DENOM_W-1:0] DENOM [SLOTS] = '{
		10'd1000, 10'd500, 10'd200, 10'd100, 10'd50, 10'd20, 10'd10, 10'd5
	};

	// ceil(2^shift / denom), exact for every 16-bit amount
	localparam logic [RECIP_W-1:0] RECIP [SLOTS] = '{
		17'd67109, 17'd67109, 17'd83887, 17'd83887,
		17'd83887, 17'd104858, 17'd104858, 17'd104858
	};

	localparam logic [SHIFT_W-1:0] SHIFT [SLOTS] = '{
		5'd26, 5'd25, 5'd24, 5'd23, 5'd22, 5'd21, 5'd20, 5'd19
	};

endpackage

`default_nettype wire

[rtl/gcd_quot_unit.sv]
// ----------------------------------------------------------------------------
// gcd_quot_unit
// per-slot coin count: amount / denomination by reciprocal, capped by the working stock
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcd_quot_unit
	import gcd_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire quot_req_t              req,
	input  wire logic [COUNT_WIDTH-1:0] work,
	output logic      [QUOT_W-1:0]      n_q
);

	localparam int PROD_W = DUE_W + RECIP_W;
	localparam int CMP_W  = (COUNT_WIDTH > QUOT_W) ? COUNT_WIDTH : QUOT_W;

	logic [PROD_W-1:0] prod;
	logic [QUOT_W-1:0] quo;
	logic [QUOT_W-1:0] n_d;

	always_comb begin
		prod = PROD_W'(req.due) * PROD_W'(RECIP[req.slot]);
		quo  = QUOT_W'(prod >> SHIFT[req.slot]);
		// limited by what the working stock holds
		if (CMP_W'(quo) <= CMP_W'(work)) begin
			n_d = quo;
		end else begin
			n_d = QUOT_W'(work);
		end
	end

	always_ff @(posedge clk) begin
		n_q <= n_d;
	end

endmodule

`default_nettype wire

[rtl/greedy_change_dispense.sv]
// ----------------------------------------------------------------------------
// greedy_change_dispense
// coin inventory with greedy change giving over eight denominations
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready) carries one item: action, denom_index,
//   load_count, change_due. a load sets one slot's stock, an insert counts one
//   paid coin as pending, a change request runs the greedy dispense.
//   load and insert items give no result; in_ready stays high for them, also
//   while an earlier result waits at the output. a change request takes the
//   block busy (in_ready low): a quotient state and a subtract state per slot
//   on one shared quotient unit and one constant multiply-subtract, eight
//   slots, then a commit state. out_valid rises as the result is committed and
//   in_ready returns in the same cycle, so a new request is taken only after
//   the last result has been committed.
//   one result item per request: change_ok and the eight give counts (all zero
//   on failure). the slot loop through the quotient unit limits throughput.
//   if out_ready is low while an earlier result waits when a new result is
//   due, the block holds in the commit state until the old result leaves; the
//   output register keeps change_ok and the counts stable while stalled.
//   arst_n clears stock and pending counts and the control state at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module greedy_change_dispense
	import gcd_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// item in
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        action,
	input  wire logic [SLOT_W-1:0] denom_index,
	input  wire logic [LOAD_W-1:0] load_count,
	input  wire logic [DUE_W-1:0]  change_due,
	// result out
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   change_ok,
	output logic [6:0]             give_1000c,
	output logic [7:0]             give_500c,
	output logic [8:0]             give_200c,
	output logic [9:0]             give_100c,
	output logic [10:0]            give_50c,
	output logic [11:0]            give_20c,
	output logic [12:0]            give_10c,
	output logic [13:0]            give_5c
);

	localparam int MW = (COUNT_WIDTH > LOAD_W) ? COUNT_WIDTH : LOAD_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	// control and inventory
	state_t                 state_q, state_d;
	slot_t                  slot_q;
	logic                   out_valid_q;
	logic [COUNT_WIDTH-1:0] stock_q [SLOTS];
	logic [COUNT_WIDTH-1:0] pend_q  [SLOTS];

	// working data of a request
	logic [DUE_W-1:0]       due_q;
	logic [COUNT_WIDTH-1:0] work_q;
	logic [COUNT_WIDTH-1:0] work_arr_q [SLOTS];
	logic [QUOT_W-1:0]      given_q    [SLOTS];

	// result register
	logic                   change_ok_q;
	logic [QUOT_W-1:0]      give_q [SLOTS];

	// datapath signals
	logic                      in_fire;
	logic                      do_quot;
	logic                      do_sub;
	logic                      do_finish;
	logic                      exact;
	slot_t                     rd_slot;
	logic [COUNT_WIDTH-1:0]    pend_rd;
	logic [COUNT_WIDTH:0]      sum;
	logic [COUNT_WIDTH-1:0]    work_sat;
	logic [COUNT_WIDTH-1:0]    load_sat;
	logic [QUOT_W-1:0]         n_q;
	logic [QUOT_W+DENOM_W-1:0] paid_out;
	quot_req_t                 qreq;

	assign in_fire = in_valid && in_ready;

	// one read port on the pending counts: item slot when idle, else the loop
	assign rd_slot = in_ready ? denom_index : slot_q;
	assign pend_rd = pend_q[rd_slot];

	// stock plus pending, saturated
	assign sum      = {1'b0, stock_q[slot_q]} + {1'b0, pend_rd};
	assign work_sat = sum[COUNT_WIDTH] ? CNT_MAX : sum[COUNT_WIDTH-1:0];

	// load value clipped to the count range
	assign load_sat = (MW'(load_count) > MW'(CNT_MAX)) ? CNT_MAX
	                                                   : COUNT_WIDTH'(load_count);

	// shared quotient unit, registered count out
	assign qreq.slot = slot_q;
	assign qreq.due  = due_q;

	gcd_quot_unit #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_quot (
		.clk  (clk),
		.req  (qreq),
		.work (work_sat),
		.n_q  (n_q)
	);

	// amount covered by this slot
	assign paid_out = (QUOT_W+DENOM_W)'(n_q) * (QUOT_W+DENOM_W)'(DENOM[slot_q]);

	assign exact = (due_q == '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && (action == ACT_CHANGE)) begin
					state_d = ST_QUOT;
				end
			end
			ST_QUOT: begin
				state_d = ST_SUB;
			end
			ST_SUB: begin
				state_d = (slot_q == SLOT_LAST) ? ST_FINISH : ST_QUOT;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		do_quot   = 1'b0;
		do_sub    = 1'b0;
		do_finish = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready  = 1'b1;
			ST_QUOT:   do_quot   = 1'b1;
			ST_SUB:    do_sub    = 1'b1;
			ST_FINISH: do_finish = !out_valid_q || out_ready;
			default:   in_ready  = 1'b0;
		endcase
	end

	// control state and inventory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				stock_q[i] <= '0;
				pend_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;

			if (in_fire) begin
				unique case (action)
					ACT_LOAD: begin
						stock_q[denom_index] <= load_sat;
					end
					ACT_INSERT: begin
						if (pend_rd != CNT_MAX) begin
							pend_q[denom_index] <= pend_rd + COUNT_WIDTH'(1);
						end
					end
					ACT_CHANGE: begin
						slot_q <= '0;
					end
					default: begin
						// unused code: no effect
					end
				endcase
			end

			if (do_sub) begin
				slot_q <= slot_q + slot_t'(1);
			end

			if (do_finish) begin
				for (int i = 0; i < SLOTS; i++) begin
					pend_q[i] <= '0;
					if (exact) begin
						stock_q[i] <= work_arr_q[i];
					end
				end
			end

			if (do_finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		if (in_fire && (action == ACT_CHANGE)) begin
			due_q <= change_due;
		end else if (do_sub) begin
			due_q <= due_q - DUE_W'(paid_out);
		end

		if (do_quot) begin
			work_q <= work_sat;
		end

		if (do_sub) begin
			work_arr_q[slot_q] <= work_q - COUNT_WIDTH'(n_q);
			given_q[slot_q]    <= n_q;
		end

		if (do_finish) begin
			change_ok_q <= exact;
			for (int i = 0; i < SLOTS; i++) begin
				give_q[i] <= exact ? given_q[i] : '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign change_ok  = change_ok_q;
	assign give_1000c = give_q[0][6:0];
	assign give_500c  = give_q[1][7:0];
	assign give_200c  = give_q[2][8:0];
	assign give_100c  = give_q[3][9:0];
	assign give_50c   = give_q[4][10:0];
	assign give_20c   = give_q[5][11:0];
	assign give_10c   = give_q[6][12:0];
	assign give_5c    = give_q[7][13:0];

endmodule

`default_nettype wire

[rtl/gcd_port_chk.sv]
// ----------------------------------------------------------------------------
// gcd_port_chk
// port-level checks of the change dispenser, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "greedy_change_dispense_assert.svh"

module gcd_port_chk
	import gcd_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic [1:0]        action,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic              change_ok,
	input wire logic [6:0]        give_1000c,
	input wire logic [7:0]        give_500c,
	input wire logic [8:0]        give_200c,
	input wire logic [9:0]        give_100c,
	input wire logic [10:0]       give_50c,
	input wire logic [11:0]       give_20c,
	input wire logic [12:0]       give_10c,
	input wire logic [13:0]       give_5c
);

	logic        in_fire;
	logic        req_fire;
	logic        upd_fire;
	logic        no_coins;
	logic [84:0] result_bits;

	assign in_fire  = in_valid && in_ready;
	assign req_fire = in_fire && (action == ACT_CHANGE);
	assign upd_fire = in_fire && (action != ACT_CHANGE) && !out_valid;
	assign no_coins = (give_1000c == '0) && (give_500c == '0) && (give_200c == '0)
	               && (give_100c == '0) && (give_50c == '0) && (give_20c == '0)
	               && (give_10c == '0) && (give_5c == '0);
	assign result_bits = {change_ok, give_1000c, give_500c, give_200c, give_100c,
	                      give_50c, give_20c, give_10c, give_5c};

	// a request keeps the block busy while the slots are worked through
	`GCD_ASSERT_NEXT(a_busy_after_request, req_fire, !in_ready, "input taken while busy")

	// a failed request hands out nothing
	`GCD_ASSERT_NOW(a_fail_gives_nothing, out_valid && !change_ok, no_coins, "coins on failure")

	// load and insert items give no result
	`GCD_ASSERT_NEXT(a_no_result_for_update, upd_fire, !out_valid, "result without a request")

	// a stalled result holds
	`GCD_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(result_bits), "stalled result changed")

endmodule

bind greedy_change_dispense gcd_port_chk u_port_chk (.*);

`default_nettype wire

[dv/greedy_change_checker.sv]
// ----------------------------------------------------------------------------
// greedy_change_checker
// watches both channels of the change dispenser, keeps its own coin inventory,
// predicts each change result and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module greedy_change_checker
	import gcd_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_ready,
	input  wire logic [1:0]        action,
	input  wire logic [SLOT_W-1:0] denom_index,
	input  wire logic [LOAD_W-1:0] load_count,
	input  wire logic [DUE_W-1:0]  change_due,
	input  wire logic              out_valid,
	input  wire logic              out_ready,
	input  wire logic              change_ok,
	input  wire logic [6:0]        give_1000c,
	input  wire logic [7:0]        give_500c,
	input  wire logic [8:0]        give_200c,
	input  wire logic [9:0]        give_100c,
	input  wire logic [10:0]       give_50c,
	input  wire logic [11:0]       give_20c,
	input  wire logic [12:0]       give_10c,
	input  wire logic [13:0]       give_5c,
	output int                     errors,
	output int                     outstanding,
	output int                     requests,
	output int                     exact
);

	typedef struct packed {
		logic        ok;
		logic [6:0]  give_1000c;
		logic [7:0]  give_500c;
		logic [8:0]  give_200c;
		logic [9:0]  give_100c;
		logic [10:0] give_50c;
		logic [11:0] give_20c;
		logic [12:0] give_10c;
		logic [13:0] give_5c;
	} change_result_t;

	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

	logic [COUNT_WIDTH-1:0] coin_stock   [SLOTS];
	logic [COUNT_WIDTH-1:0] paid_pending [SLOTS];
	change_result_t         expected_change [$];
	int                     err_count;
	int                     req_count;
	int                     exact_count;

	// greedy pass over a working copy; commits only on an exact result
	function automatic change_result_t dispense_change(input logic [DUE_W-1:0] due_in);
		longint unsigned        remaining;
		longint unsigned        avail;
		longint unsigned        take;
		longint unsigned        given [SLOTS];
		logic [COUNT_WIDTH-1:0] work  [SLOTS];
		change_result_t         res;
		remaining = due_in;
		for (int i = 0; i < SLOTS; i++) begin
			avail = longint'(coin_stock[i]) + longint'(paid_pending[i]);
			if (avail > COUNT_MAX)
				avail = COUNT_MAX;
			take = remaining / DENOM[i];
			if (take > avail)
				take = avail;
			given[i] = take;
			work[i] = COUNT_WIDTH'(avail - take);
			remaining = remaining - take * DENOM[i];
		end
		for (int i = 0; i < SLOTS; i++)
			paid_pending[i] = '0;
		res = '0;
		if (remaining == 0) begin
			for (int i = 0; i < SLOTS; i++)
				coin_stock[i] = work[i];
			res.ok         = 1'b1;
			res.give_1000c = 7'(given[0]);
			res.give_500c  = 8'(given[1]);
			res.give_200c  = 9'(given[2]);
			res.give_100c  = 10'(given[3]);
			res.give_50c   = 11'(given[4]);
			res.give_20c   = 12'(given[5]);
			res.give_10c   = 13'(given[6]);
			res.give_5c    = 14'(given[7]);
		end
		return res;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			err_count++;
		end
	endtask

	task automatic check_result();
		change_result_t want;
		if (expected_change.size() == 0) begin
			$error("change result with no request waiting");
			err_count++;
		end else begin
			want = expected_change.pop_front();
			compare_field("change_ok", want.ok, change_ok);
			compare_field("give_1000c", want.give_1000c, give_1000c);
			compare_field("give_500c", want.give_500c, give_500c);
			compare_field("give_200c", want.give_200c, give_200c);
			compare_field("give_100c", want.give_100c, give_100c);
			compare_field("give_50c", want.give_50c, give_50c);
			compare_field("give_20c", want.give_20c, give_20c);
			compare_field("give_10c", want.give_10c, give_10c);
			compare_field("give_5c", want.give_5c, give_5c);
		end
	endtask

	task automatic absorb_item();
		change_result_t res;
		case (action)
			ACT_LOAD: begin
				// load is 16 bits wide, saturate in case the count is narrower
				if (longint'(load_count) > COUNT_MAX)
					coin_stock[denom_index] = COUNT_MAX[COUNT_WIDTH-1:0];
				else
					coin_stock[denom_index] = COUNT_WIDTH'(load_count);
			end
			ACT_INSERT: begin
				if (longint'(paid_pending[denom_index]) < COUNT_MAX)
					paid_pending[denom_index] = paid_pending[denom_index] + 1'b1;
			end
			ACT_CHANGE: begin
				res = dispense_change(change_due);
				expected_change = {expected_change, res};
				req_count++;
				if (res.ok)
					exact_count++;
			end
			default: ;
		endcase
	endtask

	// output side first: a result leaving now always belongs to an older request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				coin_stock[i]   = '0;
				paid_pending[i] = '0;
			end
			expected_change.delete();
			err_count   = 0;
			req_count   = 0;
			exact_count = 0;
			errors      <= 0;
			outstanding <= 0;
			requests    <= 0;
			exact       <= 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				absorb_item();
			errors      <= err_count;
			outstanding <= expected_change.size();
			requests    <= req_count;
			exact       <= exact_count;
		end
	end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives load, insert and change items into the change dispenser with random
// gaps and output stalls; the checker beside the block predicts every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import gcd_pkg::*;

	// the fourth action code, which the block must ignore
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int         RANDOM_ITEMS = 600;
	localparam int         LONG_HOLD = 300;
	localparam int         TAIL_CYCLES = 40;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        action;
	slot_t             denom_index;
	logic [LOAD_W-1:0] load_count;
	logic [DUE_W-1:0]  change_due;
	logic              out_valid;
	logic              out_ready;
	logic              change_ok;
	logic [6:0]        give_1000c;
	logic [7:0]        give_500c;
	logic [8:0]        give_200c;
	logic [9:0]        give_100c;
	logic [10:0]       give_50c;
	logic [11:0]       give_20c;
	logic [12:0]       give_10c;
	logic [13:0]       give_5c;

	int fail_count;
	int open_requests;
	int request_total;
	int exact_total;
	int items_sent;

	// steady flags switch off the random gaps on either side
	bit tx_steady;
	bit rx_steady;
	// asks the result sink for one long hold-off
	bit rx_hold_off;

	always #1 clk = ~clk;

	greedy_change_dispense DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.denom_index (denom_index),
		.load_count  (load_count),
		.change_due  (change_due),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.change_ok   (change_ok),
		.give_1000c  (give_1000c),
		.give_500c   (give_500c),
		.give_200c   (give_200c),
		.give_100c   (give_100c),
		.give_50c    (give_50c),
		.give_20c    (give_20c),
		.give_10c    (give_10c),
		.give_5c     (give_5c)
	);

	greedy_change_checker change_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.denom_index (denom_index),
		.load_count  (load_count),
		.change_due  (change_due),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.change_ok   (change_ok),
		.give_1000c  (give_1000c),
		.give_500c   (give_500c),
		.give_200c   (give_200c),
		.give_100c   (give_100c),
		.give_50c    (give_50c),
		.give_20c    (give_20c),
		.give_10c    (give_10c),
		.give_5c     (give_5c),
		.errors      (fail_count),
		.outstanding (open_requests),
		.requests    (request_total),
		.exact       (exact_total)
	);

	// offer one item after a random gap and hold it until accepted;
	// returns at the edge of acceptance so a following item can go out at once
	task automatic send_item(input logic [1:0] act, input slot_t slot,
			input logic [LOAD_W-1:0] cnt, input logic [DUE_W-1:0] due);
		int unsigned gap;
		gap = tx_steady ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		denom_index <= slot;
		load_count  <= cnt;
		change_due  <= due;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// sender pause: hold off until every change result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (open_requests != 0) @(posedge clk);
	endtask

	// one customer visit: maybe restock, pay some coins, then ask for change;
	// now and then a stray unused action or a visit with no request at all
	task automatic run_sale();
		int unsigned    k;
		int unsigned    n;
		int unsigned    pick;
		logic [LOAD_W-1:0] cnt;
		logic [DUE_W-1:0]  due;
		n = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : 0;
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				cnt = '1;
			else if (pick == 1)
				cnt = '0;
			else if (pick < 4)
				cnt = LOAD_W'($urandom);
			else
				cnt = LOAD_W'($urandom_range(0, 40));
			send_item(ACT_LOAD, slot_t'($urandom_range(0, 7)), cnt, DUE_W'($urandom));
		end
		n = $urandom_range(0, 4);
		for (k = 0; k < n; k++)
			send_item(ACT_INSERT, slot_t'($urandom_range(0, 7)), LOAD_W'($urandom),
				DUE_W'($urandom));
		if ($urandom_range(0, 19) == 0)
			send_item(ACT_UNUSED, slot_t'($urandom_range(0, 7)), LOAD_W'($urandom),
				DUE_W'($urandom));
		if ($urandom_range(0, 9) != 0) begin
			// mostly amounts in multiples of 5 cents, some wide or odd ones
			pick = $urandom_range(0, 19);
			if (pick == 0)
				due = '0;
			else if (pick < 4)
				due = DUE_W'($urandom);
			else if (pick < 6)
				due = DUE_W'($urandom_range(0, 13107) * 5);
			else
				due = DUE_W'($urandom_range(0, 500) * 5);
			send_item(ACT_CHANGE, slot_t'($urandom_range(0, 7)), LOAD_W'($urandom), due);
		end
	endtask

	// result sink: random stall per result, plus one long hold-off on request
	initial begin : result_sink
		int unsigned stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 14);
			if (rx_hold_off) begin
				stall = LONG_HOLD;
				rx_hold_off = 1'b0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready) && !rx_hold_off) @(posedge clk);
		end
	end

	initial begin : stimulus
		int          i;
		int unsigned sale_no;
		int          random_start;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		action      <= ACT_LOAD;
		denom_index <= '0;
		load_count  <= '0;
		change_due  <= '0;
		tx_steady   = 1'b0;
		rx_steady   = 1'b0;
		rx_hold_off = 1'b0;
		items_sent  = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero due on an empty machine succeeds with nothing given
		send_item(ACT_CHANGE, slot_t'(0), '0, '0);
		// unused action with every field at its top value, no effect
		send_item(ACT_UNUSED, SLOT_LAST, '1, '1);
		// full slot plus a paid coin saturates; odd amount is refused
		send_item(ACT_LOAD, slot_t'(0), '1, '0);
		send_item(ACT_INSERT, slot_t'(0), '0, '0);
		send_item(ACT_CHANGE, slot_t'(0), '0, '1);
		for (i = 1; i < SLOTS; i++)
			send_item(ACT_LOAD, slot_t'(i), LOAD_W'(2), '0);
		send_item(ACT_INSERT, SLOT_LAST, '0, '0);
		send_item(ACT_INSERT, slot_t'(3), '0, '0);
		// one of every denomination
		send_item(ACT_CHANGE, SLOT_LAST, '1, DUE_W'(1885));
		// a large multiple of 5, mostly from the full top slot
		send_item(ACT_CHANGE, slot_t'(0), '0, DUE_W'(65530));
		send_item(ACT_LOAD, slot_t'(0), '0, '1);
		// not a multiple of 5
		send_item(ACT_CHANGE, slot_t'(0), '0, DUE_W'(3));
		// more than stock holds: refused, paid coin dropped
		send_item(ACT_INSERT, slot_t'(4), '0, '0);
		send_item(ACT_CHANGE, slot_t'(0), '0, DUE_W'(5000));
		send_item(ACT_CHANGE, slot_t'(0), '0, DUE_W'(15));
		wait_drained();

		// random visits; flags vary so gaps land on every phase of a request
		random_start = items_sent;
		sale_no = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			tx_steady = ($urandom_range(0, 5) == 0);
			rx_steady = ($urandom_range(0, 5) == 0);
			if (sale_no == 20) begin
				// long output hold-off with the sender pushing on: the
				// block fills up and holds its input
				rx_hold_off = 1'b1;
				tx_steady   = 1'b1;
				repeat (6) run_sale();
				tx_steady   = 1'b0;
			end
			if (sale_no % 40 == 39)
				wait_drained();
			run_sale();
			sale_no++;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d items: %0d change requests, %0d paid out exactly, %0d refused",
			items_sent, request_total, exact_total, request_total - exact_total);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// hard stop, far beyond the slowest correct run
	initial begin : watchdog
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/gcd_pkg.sv
rtl/gcd_quot_unit.sv
rtl/greedy_change_dispense.sv
rtl/gcd_port_chk.sv
dv/greedy_change_checker.sv
dv/testbench.sv
